// ===== rtl/fgr_pkg.sv =====
// shared constants for the fraction gcd reducer
`default_nettype none

package fgr_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 31;

endpackage

`default_nettype wire

// ===== rtl/fraction_gcd_reducer_core.sv =====
// fraction reducer: euclid gcd and two divisions on one shared radix-2 divider
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_numerator, i_denominator, i_last_in
//  out     | output    | o_out_valid / i_out_ready  | o_divisor, o_reduced_numerator,
//          |           |                            | o_reduced_denominator, o_bad_value, o_last_out
//
// one restoring divider is reused for every euclid remainder step and for both final
// divisions; at most 44 remainder steps are needed for 31-bit values. an item is taken
// only while the sequencer is idle, so a new item waits until the last one has reached
// the output register. an item with a zero operand skips the divider. reset is synchronous, active low, and
// clears the sequencer and output valid. the output register frees the input side:
// a new item is taken while a result still waits for its transfer.
`default_nettype none

module fraction_gcd_reducer_core #(
    parameter int unsigned VALUE_WIDTH = fgr_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [VALUE_WIDTH-1:0] i_numerator,
    input  wire logic [VALUE_WIDTH-1:0] i_denominator,
    input  wire logic                   i_last_in,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [VALUE_WIDTH-1:0]      o_divisor,
    output logic [VALUE_WIDTH-1:0]      o_reduced_numerator,
    output logic [VALUE_WIDTH-1:0]      o_reduced_denominator,
    output logic                        o_bad_value,
    output logic                        o_last_out
);

    localparam int unsigned W     = VALUE_WIDTH;
    localparam int unsigned CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_DIVN = 3'd2;
    localparam logic [2:0] S_DIVD = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_rem, n_rem;
    logic [W-1:0]     r_quo, n_quo;
    logic [W-1:0]     r_dvsr, n_dvsr;
    logic [W-1:0]     r_num, n_num;
    logic [W-1:0]     r_den, n_den;
    logic [W-1:0]     r_g, n_g;
    logic [W-1:0]     r_rn, n_rn;
    logic [W-1:0]     r_rd, n_rd;
    logic             r_bad, n_bad;
    logic             r_last, n_last;

    logic             r_out_valid, n_out_valid;
    logic [W-1:0]     r_o_div, n_o_div;
    logic [W-1:0]     r_o_rn, n_o_rn;
    logic [W-1:0]     r_o_rd, n_o_rd;
    logic             r_o_bad, n_o_bad;
    logic             r_o_last, n_o_last;

    // one restoring divider step
    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic         ge;
    logic [W-1:0] step_rem;
    logic [W-1:0] step_quo;
    logic         div_last;
    logic         in_xfer;
    logic         out_free;

    always_comb begin
        shifted  = {r_rem, r_quo[W-1]};
        diff     = shifted - {1'b0, r_dvsr};
        ge       = (shifted >= {1'b0, r_dvsr});
        step_rem = ge ? diff[W-1:0] : shifted[W-1:0];
        step_quo = {r_quo[W-2:0], ge};
        div_last = (r_cnt == CNT_LAST);
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dvsr      = r_dvsr;
        n_num       = r_num;
        n_den       = r_den;
        n_g         = r_g;
        n_rn        = r_rn;
        n_rd        = r_rd;
        n_bad       = r_bad;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_div     = r_o_div;
        n_o_rn      = r_o_rn;
        n_o_rd      = r_o_rd;
        n_o_bad     = r_o_bad;
        n_o_last    = r_o_last;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_num  = i_numerator;
                    n_den  = i_denominator;
                    n_last = i_last_in;
                    n_rem  = '0;
                    n_cnt  = '0;
                    if (i_numerator == '0 || i_denominator == '0) begin
                        n_bad   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_bad = 1'b0;
                        if (i_numerator >= i_denominator) begin
                            n_quo  = i_numerator;
                            n_dvsr = i_denominator;
                        end else begin
                            n_quo  = i_denominator;
                            n_dvsr = i_numerator;
                        end
                        n_state = S_GCD;
                    end
                end
            end
            S_GCD: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_cnt = r_cnt + 1'b1;
                if (div_last) begin
                    n_rem = '0;
                    n_cnt = '0;
                    if (step_rem == '0) begin
                        n_g     = r_dvsr;
                        n_quo   = r_num;
                        n_state = S_DIVN;
                    end else begin
                        n_quo  = r_dvsr;
                        n_dvsr = step_rem;
                    end
                end
            end
            S_DIVN: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_cnt = r_cnt + 1'b1;
                if (div_last) begin
                    n_rn    = step_quo;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_quo   = r_den;
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_cnt = r_cnt + 1'b1;
                if (div_last) begin
                    n_rd    = step_quo;
                    n_cnt   = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_div     = r_bad ? '0 : r_g;
                    n_o_rn      = r_bad ? '0 : r_rn;
                    n_o_rd      = r_bad ? '0 : r_rd;
                    n_o_bad     = r_bad;
                    n_o_last    = r_last;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_dvsr   <= n_dvsr;
        r_num    <= n_num;
        r_den    <= n_den;
        r_g      <= n_g;
        r_rn     <= n_rn;
        r_rd     <= n_rd;
        r_bad    <= n_bad;
        r_last   <= n_last;
        r_o_div  <= n_o_div;
        r_o_rn   <= n_o_rn;
        r_o_rd   <= n_o_rd;
        r_o_bad  <= n_o_bad;
        r_o_last <= n_o_last;
    end

    assign o_out_valid           = r_out_valid;
    assign o_divisor             = r_o_div;
    assign o_reduced_numerator   = r_o_rn;
    assign o_reduced_denominator = r_o_rd;
    assign o_bad_value           = r_o_bad;
    assign o_last_out            = r_o_last;

endmodule

`default_nettype wire

// ===== bench/fraction_gcd_reducer_core_checker.sv =====
// checker for the fraction gcd reducer: predicts each reduced fraction and compares results
`default_nettype none

module fraction_gcd_reducer_core_checker #(
    parameter int unsigned VALUE_WIDTH = fgr_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_ready,
    input  wire logic [VALUE_WIDTH-1:0] i_numerator,
    input  wire logic [VALUE_WIDTH-1:0] i_denominator,
    input  wire logic                   i_last_in,
    input  wire logic                   i_out_valid,
    input  wire logic                   i_out_ready,
    input  wire logic [VALUE_WIDTH-1:0] i_divisor,
    input  wire logic [VALUE_WIDTH-1:0] i_reduced_numerator,
    input  wire logic [VALUE_WIDTH-1:0] i_reduced_denominator,
    input  wire logic                   i_bad_value,
    input  wire logic                   i_last_out,
    output int                          o_mismatches,
    output int                          o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] divisor;
        logic [VALUE_WIDTH-1:0] reduced_numerator;
        logic [VALUE_WIDTH-1:0] reduced_denominator;
        logic                   bad_value;
        logic                   last_out;
    } t_reduced_fraction;

    t_reduced_fraction pending_fractions[$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic t_reduced_fraction reduce_fraction(
        input logic [VALUE_WIDTH-1:0] num,
        input logic [VALUE_WIDTH-1:0] den,
        input logic                   last
    );
        logic [VALUE_WIDTH-1:0] big;
        logic [VALUE_WIDTH-1:0] little;
        logic [VALUE_WIDTH-1:0] rest;
        t_reduced_fraction      r;
        r          = '0;
        r.last_out = last;
        if (num == '0 || den == '0) begin
            r.bad_value = 1'b1;
            return r;
        end
        big    = (num >= den) ? num : den;
        little = (num >= den) ? den : num;
        while (little != '0) begin
            rest   = big % little;
            big    = little;
            little = rest;
        end
        r.divisor             = big;
        r.reduced_numerator   = num / big;
        r.reduced_denominator = den / big;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (o_mismatches < 40) begin
            $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        o_mismatches = o_mismatches + 1;
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_reduced_fraction want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (pending_fractions.size() == 0) begin
                    report_mismatch("result transfer with nothing pending", 64'(i_divisor),
                                    64'd0);
                end else begin
                    want = pending_fractions.pop_front();
                    if (i_divisor !== want.divisor)
                        report_mismatch("divisor", 64'(i_divisor), 64'(want.divisor));
                    if (i_reduced_numerator !== want.reduced_numerator)
                        report_mismatch("reduced_numerator", 64'(i_reduced_numerator),
                                        64'(want.reduced_numerator));
                    if (i_reduced_denominator !== want.reduced_denominator)
                        report_mismatch("reduced_denominator", 64'(i_reduced_denominator),
                                        64'(want.reduced_denominator));
                    if (i_bad_value !== want.bad_value)
                        report_mismatch("bad_value", 64'(i_bad_value), 64'(want.bad_value));
                    if (i_last_out !== want.last_out)
                        report_mismatch("last_out", 64'(i_last_out), 64'(want.last_out));
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_fractions.push_back(reduce_fraction(i_numerator, i_denominator,
                                                            i_last_in));
            end
            o_pending = pending_fractions.size();
        end
    end

endmodule

`default_nettype wire

// ===== bench/fraction_gcd_reducer_core_tb.sv =====
// testbench top for the fraction gcd reducer: clock, reset, fraction stimulus and verdict
`default_nettype none

module fraction_gcd_reducer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned VW = fgr_pkg::VALUE_WIDTH_DEF;
    localparam logic [VW-1:0] MAX_VALUE = '1;
    localparam logic [VW-1:0] FIB_46 = VW'(1836311903);
    localparam logic [VW-1:0] FIB_45 = VW'(1134903170);

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    logic [VW-1:0] i_numerator = '0;
    logic [VW-1:0] i_denominator = '0;
    logic          i_last_in = 1'b0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    logic [VW-1:0] o_divisor;
    logic [VW-1:0] o_reduced_numerator;
    logic [VW-1:0] o_reduced_denominator;
    logic          o_bad_value;
    logic          o_last_out;

    int mismatches;
    int pending_results;
    int tx_idle_pct = 19;
    int rx_idle_pct = 50;

    fraction_gcd_reducer_core #(
        .VALUE_WIDTH(VW)
    ) i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_numerator          (i_numerator),
        .i_denominator        (i_denominator),
        .i_last_in            (i_last_in),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_divisor            (o_divisor),
        .o_reduced_numerator  (o_reduced_numerator),
        .o_reduced_denominator(o_reduced_denominator),
        .o_bad_value          (o_bad_value),
        .o_last_out           (o_last_out)
    );

    fraction_gcd_reducer_core_checker #(
        .VALUE_WIDTH(VW)
    ) i_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .i_in_ready           (o_in_ready),
        .i_numerator          (i_numerator),
        .i_denominator        (i_denominator),
        .i_last_in            (i_last_in),
        .i_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .i_divisor            (o_divisor),
        .i_reduced_numerator  (o_reduced_numerator),
        .i_reduced_denominator(o_reduced_denominator),
        .i_bad_value          (o_bad_value),
        .i_last_out           (o_last_out),
        .o_mismatches         (mismatches),
        .o_pending            (pending_results)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        #30_000_000;
        $display("fraction_gcd_reducer_core_tb: done, errors");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_fraction(input logic [VW-1:0] num, input logic [VW-1:0] den,
                                 input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_numerator   <= num;
        i_denominator <= den;
        i_last_in     <= last;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        wait (pending_results == 0);
        @(negedge i_clk);
    endtask

    function automatic logic [VW-1:0] rand_bits(input int unsigned width);
        logic [63:0] mask;
        mask = (64'd1 << width) - 64'd1;
        return VW'({$urandom, $urandom} & mask);
    endfunction

    task automatic make_fraction(output logic [VW-1:0] num, output logic [VW-1:0] den);
        int unsigned kind;
        int unsigned gw;
        logic [63:0] g;
        kind = $urandom_range(99);
        if (kind < 8) begin
            num = ($urandom_range(2) == 0) ? '0 : rand_bits(VW);
            den = (num != '0 && $urandom_range(1) == 0) ? '0 : rand_bits(VW);
            if (num != '0) den = '0;
        end else if (kind < 40) begin
            gw  = $urandom_range(1, 15);
            g   = 64'(rand_bits(gw));
            num = VW'(g * 64'(rand_bits($urandom_range(1, VW - gw))));
            den = VW'(g * 64'(rand_bits($urandom_range(1, VW - gw))));
        end else if (kind < 55) begin
            num = rand_bits(VW);
            den = rand_bits(VW);
        end else begin
            num = rand_bits($urandom_range(1, VW));
            den = rand_bits($urandom_range(1, VW));
        end
    endtask

    initial begin : stimulus
        logic [VW-1:0] num;
        logic [VW-1:0] den;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_fraction('0, VW'(5), 1'b0);
        send_fraction(VW'(7), '0, 1'b1);
        send_fraction('0, '0, 1'b0);
        send_fraction(MAX_VALUE, '0, 1'b1);
        send_fraction('0, MAX_VALUE, 1'b0);
        send_fraction(MAX_VALUE, MAX_VALUE, 1'b0);
        send_fraction(VW'(12345), VW'(12345), 1'b1);
        send_fraction(VW'(1), VW'(1), 1'b0);
        send_fraction(MAX_VALUE, VW'(1), 1'b0);
        send_fraction(VW'(1), MAX_VALUE, 1'b1);
        send_fraction(MAX_VALUE, VW'(MAX_VALUE - 1'b1), 1'b0);
        send_fraction(FIB_46, FIB_45, 1'b0);
        send_fraction(FIB_45, FIB_46, 1'b1);
        send_fraction(VW'(6), VW'(4), 1'b0);
        send_fraction(VW'(4), VW'(6), 1'b0);
        send_fraction(VW'(1) << (VW - 1), VW'(1), 1'b1);
        send_fraction(VW'(1) << (VW - 1), VW'(3) << (VW - 2), 1'b0);
        send_fraction(VW'(1000000007), VW'(998244353), 1'b0);
        send_fraction(VW'(2147483646), VW'(1431655764), 1'b1);
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 50 : 0;
            rx_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 19 : 0;
            for (int k = 0; k < 123; k++) begin
                if (phase == 1 && k == 60) begin
                    drain_results();
                end
                make_fraction(num, den);
                send_fraction(num, den, $urandom_range(7) == 0);
            end
        end

        i_in_valid <= 1'b0;
        wait (pending_results == 0);
        repeat (1600) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("fraction_gcd_reducer_core_tb: done, clean");
        end else begin
            $display("fraction_gcd_reducer_core_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
